// ===== design/msf_pkg.sv =====
package msf_pkg;

   // Command codes of the request channel
   localparam logic [1:0] CMD_BLANK = 2'd0;
   localparam logic [1:0] CMD_SPAN  = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   // Draw modes of a span
   localparam logic [1:0] MODE_SET    = 2'd0;
   localparam logic [1:0] MODE_CLEAR  = 2'd1;
   localparam logic [1:0] MODE_INVERT = 2'd2;

   localparam logic [7:0]  BYTE_ONES  = 8'hFF;
   localparam logic [7:0]  BYTE_ZEROS = 8'h00;
   localparam logic [16:0] DARK_MAX   = 17'h1FFFF;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic clear_dark;
      logic blank_write;
      logic span_read;
      logic span_write;
      logic read_issue;
      logic read_finish;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic blank_last;
      logic span_empty;
      logic span_last;
      logic rsp_free;
   } dp_status_type;

endpackage

// ===== design/monochrome_strip_span_fill_top.sv =====
// Channel   Direction  Handshake           Payload
// req       in         req_valid/req_stall command, row, x_start, x_end, draw_mode, byte_index
// rsp       out        rsp_valid/rsp_stall read_byte, bit_count, dark_total
// csr       in         csr_write_enable    blank_with_ones
//
// Steps: a blank writes the whole store, one store byte per cycle; a span reads, masks and
// writes back each byte touched, and writes nothing when it touches no byte; a read issues
// the store read, then loads the output register; an unknown command is dropped.
// Reset clears the controller, the dark total, the blank register and the result valid, not the store.
// A read beat waits in the output register while requests keep flowing; a later read
// holds in its last step, stalling the input, until that beat is taken.
module monochrome_strip_span_fill_top #(
   parameter int LINE_BYTES = 512,
   parameter int STRIP_ROWS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [3:0]  req_row,
   input  logic [11:0] req_x_start,
   input  logic [11:0] req_x_end,
   input  logic [1:0]  req_draw_mode,
   input  logic [8:0]  req_byte_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_byte,
   output logic [3:0]  rsp_bit_count,
   output logic [16:0] rsp_dark_total,
   input  logic        csr_write_enable,
   input  logic        csr_write_data
);

   msf_pkg::ctrl_cmd_type  cmd;
   msf_pkg::dp_status_type status;

   // Sequence each command: load, sweep, read-modify-write or read, then drop back to idle
   msf_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_command (req_command),
      .status      (status),
      .cmd         (cmd)
   );

   // Hold the request, address the store, mask bytes and build the read beat
   msf_datapath #(
      .LINE_BYTES (LINE_BYTES),
      .STRIP_ROWS (STRIP_ROWS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_row          (req_row),
      .req_x_start      (req_x_start),
      .req_x_end        (req_x_end),
      .req_draw_mode    (req_draw_mode),
      .req_byte_index   (req_byte_index),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_byte    (rsp_read_byte),
      .rsp_bit_count    (rsp_bit_count),
      .rsp_dark_total   (rsp_dark_total)
   );

endmodule

// ===== design/msf_ram.sv =====
module msf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic                                 rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/msf_ctrl.sv =====
module msf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_command,
   input  msf_pkg::dp_status_type status,
   output msf_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_BLANK    = 6'b000010,
      ST_SPAN_RD  = 6'b000100,
      ST_SPAN_WR  = 6'b001000,
      ST_RD_ISSUE = 6'b010000,
      ST_RD_DONE  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               case (req_command)
                  msf_pkg::CMD_BLANK: begin
                     cmd.clear_dark = 1'b1;
                     state_in       = ST_BLANK;
                  end
                  msf_pkg::CMD_SPAN: state_in = ST_SPAN_RD;
                  msf_pkg::CMD_READ: state_in = ST_RD_ISSUE;
                  default:           state_in = ST_IDLE;
               endcase
            end
         end
         ST_BLANK: begin
            cmd.blank_write = 1'b1;
            if (status.blank_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_SPAN_RD: begin
            if (status.span_empty) begin
               state_in = ST_IDLE;
            end else begin
               cmd.span_read = 1'b1;
               state_in      = ST_SPAN_WR;
            end
         end
         ST_SPAN_WR: begin
            cmd.span_write = 1'b1;
            state_in       = status.span_last ? ST_IDLE : ST_SPAN_RD;
         end
         ST_RD_ISSUE: begin
            cmd.read_issue = 1'b1;
            state_in       = ST_RD_DONE;
         end
         ST_RD_DONE: begin
            if (status.rsp_free) begin
               cmd.read_finish = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

`ifndef SYNTHESIS
   a_write_follows_read: assert property (@(posedge clock) disable iff (reset)
      cmd.span_write |-> $past(cmd.span_read))
      else $error("span write without a preceding read");

   a_finish_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.read_finish |-> status.rsp_free)
      else $error("read result loaded over a waiting beat");

   a_blank_sweep_runs: assert property (@(posedge clock) disable iff (reset)
      cmd.blank_write && !status.blank_last |=> cmd.blank_write)
      else $error("blank sweep stopped early");

   a_load_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !req_stall)
      else $error("request loaded while busy");
`endif

endmodule

// ===== design/msf_datapath.sv =====
module msf_datapath #(
   parameter int LINE_BYTES = 512,
   parameter int STRIP_ROWS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  msf_pkg::ctrl_cmd_type  cmd,
   output msf_pkg::dp_status_type status,
   input  logic [3:0]             req_row,
   input  logic [11:0]            req_x_start,
   input  logic [11:0]            req_x_end,
   input  logic [1:0]             req_draw_mode,
   input  logic [8:0]             req_byte_index,
   input  logic                   csr_write_enable,
   input  logic                   csr_write_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_read_byte,
   output logic [3:0]             rsp_bit_count,
   output logic [16:0]            rsp_dark_total
);

   localparam int DEPTH  = LINE_BYTES * STRIP_ROWS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   function automatic logic [3:0] ones_in_byte(input logic [7:0] v);
      logic [3:0] n;
      n = '0;
      for (int i = 0; i < 8; i++) begin
         n = n + 4'(v[i]);
      end
      return n;
   endfunction

   logic              blank_with_ones_ff;
   logic [ADDR_W-1:0] base_ff, blank_addr_ff;
   logic [8:0]        col_ff, bl_ff, bh_ff, last_col_ff, byte_index_ff;
   logic [2:0]        b1_ff, b2_ff;
   logic [1:0]        mode_ff;
   logic              span_empty_ff, read_ok_ff;
   logic [16:0]       dark_ff;
   logic              rsp_valid_ff;
   logic [7:0]        rsp_byte_ff;
   logic [3:0]        rsp_count_ff;
   logic [16:0]       rsp_total_ff;

   logic [11:0]       lo, hi;
   logic [8:0]        bl_in, bh_in;
   logic              row_ok;
   logic [ADDR_W-1:0] span_addr, read_addr;
   logic [7:0]        rd_data, mask, modified;
   logic [3:0]        count;
   logic [17:0]       dark_sum;
   logic [16:0]       dark_in;

   // Order the span ends and find its byte columns
   assign lo     = (req_x_start > req_x_end) ? req_x_end : req_x_start;
   assign hi     = (req_x_start > req_x_end) ? req_x_start : req_x_end;
   assign bl_in  = lo[11:3];
   assign bh_in  = hi[11:3];
   assign row_ok = (32'(req_row) < STRIP_ROWS);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         base_ff       <= ADDR_W'(32'(req_row) * LINE_BYTES);
         bl_ff         <= bl_in;
         bh_ff         <= bh_in;
         b1_ff         <= lo[2:0];
         b2_ff         <= hi[2:0];
         col_ff        <= bl_in;
         last_col_ff   <= (32'(bh_in) < LINE_BYTES) ? bh_in : 9'(LINE_BYTES - 1);
         mode_ff       <= req_draw_mode;
         span_empty_ff <= !row_ok || (req_draw_mode > msf_pkg::MODE_INVERT) ||
                          !(32'(bl_in) < LINE_BYTES);
         byte_index_ff <= req_byte_index;
         read_ok_ff    <= row_ok && (32'(req_byte_index) < LINE_BYTES);
         blank_addr_ff <= '0;
      end else begin
         if (cmd.blank_write) begin
            blank_addr_ff <= blank_addr_ff + ADDR_W'(1);
         end
         if (cmd.span_write) begin
            col_ff <= col_ff + 9'd1;
         end
      end
   end

   assign span_addr = base_ff + ADDR_W'(col_ff);
   assign read_addr = base_ff + ADDR_W'(byte_index_ff);

   // Mask off the partial bytes at either end
   always_comb begin
      mask = msf_pkg::BYTE_ONES;
      if (col_ff == bl_ff) begin
         mask = mask & (msf_pkg::BYTE_ONES >> b1_ff);
      end
      if (col_ff == bh_ff) begin
         mask = mask & (msf_pkg::BYTE_ONES << (3'd7 - b2_ff));
      end
      case (mode_ff)
         msf_pkg::MODE_SET:    modified = rd_data | mask;
         msf_pkg::MODE_CLEAR:  modified = rd_data & ~mask;
         msf_pkg::MODE_INVERT: modified = rd_data ^ mask;
         default:              modified = rd_data;
      endcase
   end

   msf_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.blank_write || cmd.span_write),
      .wr_addr (cmd.blank_write ? blank_addr_ff : span_addr),
      .wr_data (cmd.blank_write ? (blank_with_ones_ff ? msf_pkg::BYTE_ONES
                                                      : msf_pkg::BYTE_ZEROS)
                                : modified),
      .rd_en   (cmd.span_read || (cmd.read_issue && read_ok_ff)),
      .rd_addr (cmd.span_read ? span_addr : read_addr),
      .rd_data (rd_data)
   );

   // Saturating running total of set bits in the bytes read
   assign count    = read_ok_ff ? ones_in_byte(rd_data) : 4'd0;
   assign dark_sum = {1'b0, dark_ff} + 18'(count);
   assign dark_in  = dark_sum[17] ? msf_pkg::DARK_MAX : dark_sum[16:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         blank_with_ones_ff <= 1'b0;
         dark_ff            <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            blank_with_ones_ff <= csr_write_data;
         end
         if (cmd.clear_dark) begin
            dark_ff <= '0;
         end else if (cmd.read_finish) begin
            dark_ff <= dark_in;
         end
         if (cmd.read_finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read_finish) begin
         rsp_byte_ff  <= read_ok_ff ? rd_data : 8'd0;
         rsp_count_ff <= count;
         rsp_total_ff <= dark_in;
      end
   end

   assign status.blank_last = (blank_addr_ff == ADDR_W'(DEPTH - 1));
   assign status.span_empty = span_empty_ff;
   assign status.span_last  = (col_ff == last_col_ff);
   assign status.rsp_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_byte  = rsp_byte_ff;
   assign rsp_bit_count  = rsp_count_ff;
   assign rsp_dark_total = rsp_total_ff;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

localparam int LINE_BYTES  = 512;
localparam int STRIP_ROWS  = 16;
localparam int STORE_BYTES = LINE_BYTES * STRIP_ROWS;

// Codes the block has to ignore
localparam logic [1:0] CMD_UNUSED  = 2'd3;
localparam logic [1:0] MODE_UNUSED = 2'd3;

typedef struct packed {
   logic [1:0]  command;
   logic [3:0]  row;
   logic [11:0] x_start;
   logic [11:0] x_end;
   logic [1:0]  draw_mode;
   logic [8:0]  byte_index;
} strip_cmd_type;

typedef struct packed {
   logic [7:0]  read_byte;
   logic [3:0]  bit_count;
   logic [16:0] dark_total;
} pixel_read_type;

class strip_mirror_type;
   logic [7:0]     pixels [STORE_BYTES];
   logic [16:0]    dark_sum;
   logic           fill_ones;
   pixel_read_type awaited [$];
   int unsigned    mismatches;
   int unsigned    reads_checked;

   function new();
      foreach (pixels[i]) pixels[i] = msf_pkg::BYTE_ZEROS;
      dark_sum      = '0;
      fill_ones     = 1'b0;
      mismatches    = 0;
      reads_checked = 0;
   endfunction

   function int unsigned awaiting();
      return awaited.size();
   endfunction

   // Apply one accepted request beat to the mirrored strip.
   function void note_command(strip_cmd_type c);
      logic [11:0]    lo;
      logic [11:0]    hi;
      logic [7:0]     mask;
      logic [17:0]    total;
      int             base;
      int             col;
      pixel_read_type r;
      case (c.command)
         msf_pkg::CMD_BLANK: begin
            foreach (pixels[i])
               pixels[i] = fill_ones ? msf_pkg::BYTE_ONES : msf_pkg::BYTE_ZEROS;
            dark_sum = '0;
         end
         msf_pkg::CMD_SPAN: begin
            if (int'(c.row) < STRIP_ROWS && c.draw_mode != MODE_UNUSED) begin
               lo   = (c.x_start > c.x_end) ? c.x_end : c.x_start;
               hi   = (c.x_start > c.x_end) ? c.x_start : c.x_end;
               base = int'(c.row) * LINE_BYTES;
               for (col = int'(lo[11:3]); col <= int'(hi[11:3]) && col < LINE_BYTES;
                    col++) begin
                  mask = msf_pkg::BYTE_ONES;
                  if (col == int'(lo[11:3]))
                     mask = mask & (msf_pkg::BYTE_ONES >> lo[2:0]);
                  if (col == int'(hi[11:3]))
                     mask = mask & (msf_pkg::BYTE_ONES << (3'd7 - hi[2:0]));
                  case (c.draw_mode)
                     msf_pkg::MODE_SET:
                        pixels[base + col] = pixels[base + col] | mask;
                     msf_pkg::MODE_CLEAR:
                        pixels[base + col] = pixels[base + col] & ~mask;
                     default:
                        pixels[base + col] = pixels[base + col] ^ mask;
                  endcase
               end
            end
         end
         msf_pkg::CMD_READ: begin
            r.read_byte = msf_pkg::BYTE_ZEROS;
            r.bit_count = '0;
            if (int'(c.row) < STRIP_ROWS && int'(c.byte_index) < LINE_BYTES) begin
               r.read_byte = pixels[int'(c.row) * LINE_BYTES + int'(c.byte_index)];
               r.bit_count = 4'($countones(r.read_byte));
               total       = {1'b0, dark_sum} + 18'(r.bit_count);
               dark_sum    = (total > 18'(msf_pkg::DARK_MAX)) ? msf_pkg::DARK_MAX
                                                               : total[16:0];
            end
            r.dark_total = dark_sum;
            awaited.insert(awaited.size(), r);
         end
         default: ;
      endcase
   endfunction

   task report_mismatch(input string what);
      $display("MISMATCH: %s", what);
      mismatches++;
   endtask

   // Compare one accepted result beat with the oldest awaited read.
   task check_beat(input pixel_read_type got);
      pixel_read_type want;
      if (awaited.size() == 0) begin
         report_mismatch($sformatf("result beat %0h with no read awaited", got));
         return;
      end
      want = awaited.pop_front();
      reads_checked++;
      if (got.read_byte !== want.read_byte)
         report_mismatch($sformatf("read_byte %h, expected %h", got.read_byte,
                                   want.read_byte));
      if (got.bit_count !== want.bit_count)
         report_mismatch($sformatf("bit_count %0d, expected %0d", got.bit_count,
                                   want.bit_count));
      if (got.dark_total !== want.dark_total)
         report_mismatch($sformatf("dark_total %0d, expected %0d", got.dark_total,
                                   want.dark_total));
   endtask
endclass

module testbench;

   localparam int SETTLE_CYCLES = STORE_BYTES + 200;  // a blank walks the whole store
   localparam int QUIET_LIMIT   = 100000;
   localparam int HOLD_CYCLES   = 1500;
   localparam int RANDOM_ITEMS  = 380;
   localparam int FULL_READS    = 40;                 // reads of an all-ones strip

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   logic [1:0]  req_command      = CMD_UNUSED;
   logic [3:0]  req_row          = '0;
   logic [11:0] req_x_start      = '0;
   logic [11:0] req_x_end        = '0;
   logic [1:0]  req_draw_mode    = msf_pkg::MODE_SET;
   logic [8:0]  req_byte_index   = '0;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   logic [7:0]  rsp_read_byte;
   logic [3:0]  rsp_bit_count;
   logic [16:0] rsp_dark_total;
   logic        csr_write_enable = 1'b0;
   logic        csr_write_data   = 1'b0;

   strip_mirror_type mirror;

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned quiet_cycles  = 0;
   bit          hold_pending  = 1'b0;
   int unsigned hold_left     = 0;
   int unsigned blanks_sent   = 0;
   int unsigned spans_sent    = 0;
   int unsigned reads_sent    = 0;
   int unsigned ignored_sent  = 0;

   // Locality of the random stream: reads mostly land near the last span
   logic [3:0]  recent_row = '0;
   int          recent_col = 0;

   monochrome_strip_span_fill_top #(
      .LINE_BYTES(LINE_BYTES),
      .STRIP_ROWS(STRIP_ROWS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_row          (req_row),
      .req_x_start      (req_x_start),
      .req_x_end        (req_x_end),
      .req_draw_mode    (req_draw_mode),
      .req_byte_index   (req_byte_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_byte    (rsp_read_byte),
      .rsp_bit_count    (rsp_bit_count),
      .rsp_dark_total   (rsp_dark_total),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #1 clock = ~clock;

   // Watchdog: end the run if no beat of any kind moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          csr_write_enable) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Watchdog: no beat for %0d cycles", QUIET_LIMIT);
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Result side: sample the beat with the values from before the edge, then
   // pick the stall for the next cycle. A long hold-off is counted here.
   initial begin
      pixel_read_type got;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            got = {rsp_read_byte, rsp_bit_count, rsp_dark_total};
            mirror.check_beat(got);
         end
         if (hold_pending) begin
            hold_left    = HOLD_CYCLES;
            hold_pending = 1'b0;
         end
         if (hold_left != 0) hold_left--;
         rsp_stall <= (hold_left != 0) || ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   function automatic strip_cmd_type make_cmd(input logic [1:0] command,
                                              input logic [3:0] row,
                                              input logic [11:0] x_start,
                                              input logic [11:0] x_end,
                                              input logic [1:0] draw_mode,
                                              input logic [8:0] byte_index);
      strip_cmd_type c;
      c.command    = command;
      c.row        = row;
      c.x_start    = x_start;
      c.x_end      = x_end;
      c.draw_mode  = draw_mode;
      c.byte_index = byte_index;
      return c;
   endfunction

   // Mostly short spans and reads close to them; some whole-range noise.
   function automatic strip_cmd_type random_command();
      strip_cmd_type c;
      int unsigned   roll;
      int            stretch;
      int            pos;
      c.command    = msf_pkg::CMD_READ;
      c.row        = 4'($urandom);
      c.x_start    = 12'($urandom);
      c.x_end      = 12'($urandom);
      c.draw_mode  = 2'($urandom);
      c.byte_index = 9'($urandom);
      roll = $urandom_range(0, 999);
      if (roll < 5) begin
         c.command = msf_pkg::CMD_BLANK;
      end else if (roll < 35) begin
         c.command = CMD_UNUSED;
      end else if (roll < 500) begin
         c.command = msf_pkg::CMD_SPAN;
         if ($urandom_range(0, 3) != 0) c.row = recent_row;
         c.draw_mode = ($urandom_range(0, 19) == 0) ? MODE_UNUSED
                                                    : 2'($urandom_range(0, 2));
         roll = $urandom_range(0, 99);
         if (roll < 85) begin
            stretch = int'($urandom_range(0, 40));
            if ($urandom_range(0, 1) != 0) stretch = -stretch;
            pos = int'(c.x_start) + stretch;
            if (pos < 0) pos = 0;
            if (pos > 4095) pos = 4095;
            c.x_end = 12'(pos);
         end else if (roll >= 95) begin
            c.x_start = ($urandom_range(0, 1) != 0) ? 12'd0 : 12'hFFF;
            c.x_end   = ~c.x_start;
         end
         recent_row = c.row;
         recent_col = int'(c.x_start[11:3]);
      end else begin
         if ($urandom_range(0, 3) != 0) begin
            c.row = recent_row;
            pos = recent_col + int'($urandom_range(0, 12)) - 6;
            if (pos < 0) pos = 0;
            if (pos > LINE_BYTES - 1) pos = LINE_BYTES - 1;
            c.byte_index = 9'(pos);
         end
      end
      return c;
   endfunction

   // Offer one request beat and hold it until the block takes it.
   task automatic offer_command(input strip_cmd_type c);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_command    <= c.command;
      req_row        <= c.row;
      req_x_start    <= c.x_start;
      req_x_end      <= c.x_end;
      req_draw_mode  <= c.draw_mode;
      req_byte_index <= c.byte_index;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      mirror.note_command(c);
      case (c.command)
         msf_pkg::CMD_BLANK: blanks_sent++;
         msf_pkg::CMD_SPAN:  spans_sent++;
         msf_pkg::CMD_READ:  reads_sent++;
         default:            ignored_sent++;
      endcase
   endtask

   // Drop valid, wait for every awaited read, then let a blank or a long span
   // finish inside the block, since those leave no result to wait on.
   task automatic drain();
      req_valid <= 1'b0;
      while (mirror.awaiting() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_blank_fill(input logic ones);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= ones;
      @(posedge clock);
      mirror.fill_ones  = ones;
      csr_write_enable <= 1'b0;
   endtask

   task automatic random_run(input int items, input bit with_hold);
      for (int i = 0; i < items; i++) begin
         if (with_hold && i == 50) hold_pending = 1'b1;
         offer_command(random_command());
      end
   endtask

   initial begin
      mirror = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Phase one: blank to zeros, sparse sender gaps, heavy result stalls.
      write_blank_fill(1'b0);
      send_idle_pct = 9;
      recv_idle_pct = 61;
      offer_command(make_cmd(msf_pkg::CMD_BLANK, 4'd0, 12'd0, 12'd0, msf_pkg::MODE_SET,
                             9'd0));
      offer_command(make_cmd(msf_pkg::CMD_READ, 4'd0, 12'd0, 12'd0, msf_pkg::MODE_SET,
                             9'd0));
      // whole line, both ends of the row
      offer_command(make_cmd(msf_pkg::CMD_SPAN, 4'd0, 12'd0, 12'hFFF, msf_pkg::MODE_SET,
                             9'd0));
      offer_command(make_cmd(msf_pkg::CMD_READ, 4'd0, 12'd0, 12'd0, msf_pkg::MODE_SET,
                             9'd0));
      offer_command(make_cmd(msf_pkg::CMD_READ, 4'd0, 12'd0, 12'd0, msf_pkg::MODE_SET,
                             9'd511));
      // reversed ends, partial bytes at both ends
      offer_command(make_cmd(msf_pkg::CMD_SPAN, 4'd0, 12'd13, 12'd2, msf_pkg::MODE_CLEAR,
                             9'd0));
      offer_command(make_cmd(msf_pkg::CMD_READ, 4'd0, 12'd0, 12'd0, msf_pkg::MODE_SET,
                             9'd0));
      offer_command(make_cmd(msf_pkg::CMD_READ, 4'd0, 12'd0, 12'd0, msf_pkg::MODE_SET,
                             9'd1));
      // single pixel inside one byte
      offer_command(make_cmd(msf_pkg::CMD_SPAN, 4'd0, 12'd3, 12'd3, msf_pkg::MODE_INVERT,
                             9'd0));
      offer_command(make_cmd(msf_pkg::CMD_READ, 4'd0, 12'd0, 12'd0, msf_pkg::MODE_SET,
                             9'd0));
      // unknown draw mode leaves the line alone
      offer_command(make_cmd(msf_pkg::CMD_SPAN, 4'd0, 12'd0, 12'hFFF, MODE_UNUSED, 9'd0));
      offer_command(make_cmd(msf_pkg::CMD_READ, 4'd0, 12'd0, 12'd0, msf_pkg::MODE_SET,
                             9'd5));
      offer_command(make_cmd(CMD_UNUSED, 4'hF, 12'hFFF, 12'hFFF, MODE_UNUSED, 9'h1FF));
      // last byte of the last row, reversed
      offer_command(make_cmd(msf_pkg::CMD_SPAN, 4'd15, 12'hFFF, 12'd4088,
                             msf_pkg::MODE_SET, 9'd0));
      offer_command(make_cmd(msf_pkg::CMD_READ, 4'd15, 12'd0, 12'd0, msf_pkg::MODE_SET,
                             9'd511));
      offer_command(make_cmd(msf_pkg::CMD_READ, 4'd15, 12'd0, 12'd0, msf_pkg::MODE_SET,
                             9'd510));
      // span aligned exactly on a byte
      offer_command(make_cmd(msf_pkg::CMD_SPAN, 4'd7, 12'd8, 12'd15, msf_pkg::MODE_INVERT,
                             9'd0));
      offer_command(make_cmd(msf_pkg::CMD_READ, 4'd7, 12'd0, 12'd0, msf_pkg::MODE_SET,
                             9'd1));
      offer_command(make_cmd(msf_pkg::CMD_READ, 4'd7, 12'd0, 12'd0, msf_pkg::MODE_SET,
                             9'd0));
      offer_command(make_cmd(msf_pkg::CMD_READ, 4'd7, 12'd0, 12'd0, msf_pkg::MODE_SET,
                             9'd2));
      random_run(RANDOM_ITEMS, 1'b0);

      // Phase two: blank to ones, the sender idles, the result side rarely stalls.
      write_blank_fill(1'b1);
      send_idle_pct = 61;
      recv_idle_pct = 9;
      offer_command(make_cmd(msf_pkg::CMD_BLANK, 4'd0, 12'd0, 12'd0, msf_pkg::MODE_SET,
                             9'd0));
      random_run(RANDOM_ITEMS, 1'b0);

      // Phase three: back to zeros, no idling, one long hold-off on results
      // so that reads back up and the block stalls its input.
      write_blank_fill(1'b0);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      offer_command(make_cmd(msf_pkg::CMD_BLANK, 4'd0, 12'd0, 12'd0, msf_pkg::MODE_SET,
                             9'd0));
      random_run(RANDOM_ITEMS, 1'b1);

      // Phase four: all-ones strip read at random places.
      write_blank_fill(1'b1);
      offer_command(make_cmd(msf_pkg::CMD_BLANK, 4'd0, 12'd0, 12'd0, msf_pkg::MODE_SET,
                             9'd0));
      for (int i = 0; i < FULL_READS; i++)
         offer_command(make_cmd(msf_pkg::CMD_READ, 4'($urandom), 12'($urandom),
                                12'($urandom), 2'($urandom), 9'($urandom)));

      drain();
      if (mirror.awaiting() != 0)
         mirror.report_mismatch($sformatf("%0d reads never answered", mirror.awaiting()));

      $display("Covered %0d blanks, %0d spans, %0d reads (%0d checked), %0d ignored beats",
               blanks_sent, spans_sent, reads_sent, mirror.reads_checked, ignored_sent);
      $display("Both blank fills, all draw modes, idle mixes, back-pressure, full-byte reads");
      if (mirror.mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
